@@ sv/square_wave_note_sequencer_top_defines.svh @@
// Assertion macros shared by the note sequencer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SQUARE_WAVE_NOTE_SEQUENCER_TOP_DEFINES_SVH
`define SQUARE_WAVE_NOTE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SWNS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SWNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/swns_pkg.sv @@
// Types, constants and helper functions of the square-wave note sequencer.
// Depends on nothing; imported by every module of the block.
package swns_pkg;

    // Field and register widths
    localparam int HZ_W    = 28;
    localparam int CPM_W   = 18;
    localparam int GAP_W   = 10;
    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 16;
    localparam int PAT_W   = 4;
    localparam int HALF_W  = HZ_W - 1;
    localparam int CFG_W   = HZ_W;
    localparam int IDX_W   = 2;
    localparam int S_DATA_W = FREQ_W + DUR_W;
    localparam int M_DATA_W = 8;
    localparam int STEP_W  = 5;

    // Register reset values
    localparam logic [HZ_W-1:0]  CLOCK_HZ_RST      = 28'd72000000;
    localparam logic [CPM_W-1:0] CLOCKS_PER_MS_RST = 18'd72000;
    localparam logic [GAP_W-1:0] GAP_MS_RST        = 10'd50;

    // Divider runs one quotient bit per cycle
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(HZ_W - 1);

    // Pitch band thresholds and patterns
    localparam logic [FREQ_W-1:0] BAND_LOW_HZ  = 16'd300;
    localparam logic [FREQ_W-1:0] BAND_MID_HZ  = 16'd350;
    localparam logic [FREQ_W-1:0] BAND_HIGH_HZ = 16'd400;
    localparam logic [PAT_W-1:0]  PAT_NONE = 4'h0;
    localparam logic [PAT_W-1:0]  PAT_ONE  = 4'h1;
    localparam logic [PAT_W-1:0]  PAT_TWO  = 4'h3;
    localparam logic [PAT_W-1:0]  PAT_THREE = 4'h7;
    localparam logic [PAT_W-1:0]  PAT_ALL  = 4'hF;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_CLOCK_HZ      = 2'd0,
        REG_CLOCKS_PER_MS = 2'd1,
        REG_GAP_MS        = 2'd2
    } reg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIRST,
        ST_NOTE,
        ST_GAP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start_load;   // latch note, start period division
        logic load_period;  // division done: arm phase and ms timers
        logic note_tick;    // run one tick of a sounding note
        logic gap_tick;     // run one tick of the silent gap
        logic idle_tick;    // emit one idle tick
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;     // result register can take a beat
        logic note_req;     // input beat carries a playable note
        logic div_done;     // quotient is ready
        logic ms_expire;    // this tick ends the current ms count
        logic gap_zero;     // no gap follows the note
    } status_t;

    function automatic logic [PAT_W-1:0] band_of(input logic [FREQ_W-1:0] f);
        logic [PAT_W-1:0] p;
        if (f == '0)               p = PAT_NONE;
        else if (f < BAND_LOW_HZ)  p = PAT_ONE;
        else if (f < BAND_MID_HZ)  p = PAT_TWO;
        else if (f < BAND_HIGH_HZ) p = PAT_THREE;
        else                       p = PAT_ALL;
        return p;
    endfunction

endpackage

@@ sv/swns_div.sv @@
// Restoring divider, one quotient bit per cycle, for the tone period.
// Depends on swns_pkg.
module swns_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [swns_pkg::HZ_W-1:0]   dividend,
    input  logic [swns_pkg::FREQ_W-1:0] divisor,
    output logic                       done,
    output logic [swns_pkg::HZ_W-1:0]   quotient
);
    import swns_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [HZ_W-1:0]     quo_reg, quo_next;
    logic [FREQ_W-1:0]   rem_reg, rem_next;
    logic [FREQ_W-1:0]   dsr_reg, dsr_next;
    logic [FREQ_W:0]     shifted;
    logic [FREQ_W:0]     diff;
    logic                fits;

    // Trial subtract of the next partial remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[HZ_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    // Step the division
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = DIV_LAST_STEP;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[HZ_W-2:0], fits};
            rem_next = fits ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/swns_datapath.sv @@
// Datapath of the note sequencer: config registers, period divider, phase and
// millisecond counters, result register. Depends on swns_pkg and swns_div.
module swns_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [swns_pkg::IDX_W-1:0]     cfg_index,
    input  logic [swns_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tuser,
    input  logic [swns_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [swns_pkg::M_DATA_W-1:0]  m_tdata,
    input  swns_pkg::cmd_t                cmd,
    output swns_pkg::status_t             status
);
    import swns_pkg::*;

    logic [HZ_W-1:0]   clock_hz_reg;
    logic [CPM_W-1:0]  cpm_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic [HZ_W-1:0]   period_reg, period_next;
    logic [HALF_W-1:0] half_reg, half_next;
    logic [HZ_W-1:0]   phase_reg, phase_next;
    logic [CPM_W-1:0]  prescale_reg, prescale_next;
    logic [DUR_W-1:0]  remaining_reg, remaining_next;
    logic [PAT_W-1:0]  pattern_reg, pattern_next;
    logic              freq_zero_reg, freq_zero_next;
    logic              out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic [FREQ_W-1:0] in_freq;
    logic [DUR_W-1:0]  in_dur;
    logic [HZ_W-1:0]   quotient;
    logic              div_done;
    logic [CPM_W-1:0]  cpm_eff;
    logic              pre_wrap;
    logic              ms_expire;
    logic              phase_wrap;
    logic              tone;
    logic              any_tick;
    logic              timed_tick;

    assign in_freq = s_tdata[FREQ_W-1:0];
    assign in_dur  = s_tdata[S_DATA_W-1:FREQ_W];

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RST;
            cpm_reg      <= CLOCKS_PER_MS_RST;
            gap_reg      <= GAP_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CLOCK_HZ:      clock_hz_reg <= cfg_wdata[HZ_W-1:0];
                REG_CLOCKS_PER_MS: cpm_reg      <= cfg_wdata[CPM_W-1:0];
                REG_GAP_MS:        gap_reg      <= cfg_wdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    swns_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_load),
        .dividend (clock_hz_reg),
        .divisor  (in_freq),
        .done     (div_done),
        .quotient (quotient)
    );

    // Tick conditions: ms timer, phase wrap, tone level
    always_comb begin
        cpm_eff    = (cpm_reg == '0) ? CPM_W'(1) : cpm_reg;
        pre_wrap   = ({1'b0, prescale_reg} + 1'b1) >= {1'b0, cpm_eff};
        ms_expire  = pre_wrap && (remaining_reg <= DUR_W'(1));
        phase_wrap = ({1'b0, phase_reg} + 1'b1) >= {1'b0, period_reg};
        tone       = (period_reg != '0) && (phase_reg >= {1'b0, half_reg});
        timed_tick = cmd.note_tick || cmd.gap_tick;
        any_tick   = timed_tick || cmd.idle_tick;
    end

    // Advance note state
    always_comb begin
        period_next    = period_reg;
        half_next      = half_reg;
        phase_next     = phase_reg;
        prescale_next  = prescale_reg;
        remaining_next = remaining_reg;
        pattern_next   = pattern_reg;
        freq_zero_next = freq_zero_reg;

        if (cmd.start_load) begin
            remaining_next = in_dur;
            pattern_next   = band_of(in_freq);
            freq_zero_next = (in_freq == '0);
        end

        if (cmd.load_period) begin
            period_next   = freq_zero_reg ? '0 : quotient;
            half_next     = freq_zero_reg ? '0 : quotient[HZ_W-1:1];
            phase_next    = '0;
            prescale_next = '0;
        end

        if (cmd.note_tick) begin
            phase_next = phase_wrap ? '0 : phase_reg + 1'b1;
        end

        if (timed_tick) begin
            if (pre_wrap) begin
                prescale_next  = '0;
                remaining_next = (remaining_reg <= DUR_W'(1)) ? '0 : remaining_reg - 1'b1;
            end else begin
                prescale_next = prescale_reg + 1'b1;
            end
            if (ms_expire) begin
                if (cmd.note_tick) begin
                    remaining_next = DUR_W'(gap_reg);
                    prescale_next  = '0;
                    if (gap_reg == '0) begin
                        pattern_next = PAT_NONE;
                    end
                end else begin
                    pattern_next = PAT_NONE;
                end
            end
        end
    end

    // Load the result register; hold it until the beat is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (any_tick) begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0,
                              (cmd.note_tick && ms_expire && gap_reg == '0) ||
                              (cmd.gap_tick && ms_expire),
                              timed_tick,
                              pattern_reg,
                              cmd.note_tick && tone};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= '0;
            half_reg      <= '0;
            phase_reg     <= '0;
            prescale_reg  <= '0;
            remaining_reg <= '0;
            pattern_reg   <= PAT_NONE;
            freq_zero_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            period_reg    <= period_next;
            half_reg      <= half_next;
            phase_reg     <= phase_next;
            prescale_reg  <= prescale_next;
            remaining_reg <= remaining_next;
            pattern_reg   <= pattern_next;
            freq_zero_reg <= freq_zero_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Report status to the controller
    always_comb begin
        status.out_free  = !out_valid_reg || m_tready;
        status.note_req  = s_tuser && (in_dur != '0);
        status.div_done  = div_done;
        status.ms_expire = ms_expire;
        status.gap_zero  = (gap_reg == '0);
    end

endmodule

@@ sv/swns_ctrl.sv @@
// Controller of the note sequencer: play state machine and input handshake.
// Depends on swns_pkg and the shared assertion macros.
`include "square_wave_note_sequencer_top_defines.svh"

module swns_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  swns_pkg::status_t status,
    output swns_pkg::cmd_t    cmd
);
    import swns_pkg::*;

    state_t state_reg, state_next;
    logic   fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Take a beat only in states that consume one tick per beat
    always_comb begin
        unique case (state_reg) inside
            ST_IDLE, ST_NOTE, ST_GAP: s_tready = status.out_free;
            default:                  s_tready = 1'b0;
        endcase
    end

    assign fire = s_tvalid && s_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE: begin
                if (fire && status.note_req) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.div_done) state_next = ST_FIRST;
            end
            ST_FIRST, ST_NOTE: begin
                if ((state_reg == ST_FIRST && status.out_free) || fire) begin
                    if (status.ms_expire) begin
                        state_next = status.gap_zero ? ST_IDLE : ST_GAP;
                    end else begin
                        state_next = ST_NOTE;
                    end
                end
            end
            ST_GAP: begin
                if (fire && status.ms_expire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.start_load = fire && status.note_req;
                cmd.idle_tick  = fire && !status.note_req;
            end
            ST_LOAD:  cmd.load_period = status.div_done;
            ST_FIRST: cmd.note_tick   = status.out_free;
            ST_NOTE:  cmd.note_tick   = fire;
            ST_GAP:   cmd.gap_tick    = fire;
            default: ;
        endcase
    end

    `SWNS_ASSERT_NOW(a_no_take_in_load, aclk, aresetn, (state_reg == ST_LOAD || state_reg == ST_FIRST), !s_tready, "beat taken while a note loads")
    `SWNS_ASSERT_NOW(a_one_cmd, aclk, aresetn, 1'b1, $onehot0(cmd), "more than one datapath command")
    `SWNS_ASSERT_NOW(a_div_in_load, aclk, aresetn, status.div_done, state_reg == ST_LOAD, "quotient ready outside of note load")
    `SWNS_ASSERT_NEXT(a_start_to_load, aclk, aresetn, cmd.start_load, state_reg == ST_LOAD, "note start did not enter load")

endmodule

@@ sv/square_wave_note_sequencer_top.sv @@
// Square-wave note sequencer, top level: controller plus datapath.
// Depends on swns_pkg, swns_ctrl and swns_datapath.
//
// Each input beat is one tick of a tone generator and yields one result beat.
// A tick's result is registered as its beat is taken, except the tick
// that starts a note: its tone period (clock_hz / frequency) comes from a
// restoring divider that makes one quotient bit per cycle, so that tick's
// result follows the divider's 28 steps, the load state and the first-tick
// state, and no beat is taken meanwhile. A note beat is acted on only while idle;
// a zero duration is ignored. Configuration writes belong to idle periods.
module square_wave_note_sequencer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [swns_pkg::IDX_W-1:0]     cfg_index,
    input  logic [swns_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swns_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] frequency, [31:16] duration
    input  logic                          s_tuser,   // [0] note_valid
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [swns_pkg::M_DATA_W-1:0]  m_tdata    // [0] tone_out, [4:1] level_pattern,
                                                      // [5] busy_res, [6] note_done, [7] zero
);
    import swns_pkg::*;

    cmd_t    cmd;
    status_t status;

    swns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swns_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
